@@ rtl/tts_pkg.sv @@
// -----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, constants and helpers for the Thomas algorithm solver.
// -----------------------------------------------------------------------------
package tts_pkg;

    localparam int MAX_ROWS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] sub_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] super_coef;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } row_word_t;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [ROW_W-1:0]   row_index;
        logic               last_out;
        logic               singular;
    } result_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEED, ST_MUL_C, ST_MUL_Y, ST_FDIV, ST_FWAIT, ST_WRITE,
        ST_BREAD, ST_BMUL, ST_BSUB, ST_BDIV, ST_BWAIT, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SEED, OP_MUL_C, OP_MUL_Y, OP_FDIV, OP_FLATCH,
        OP_WRITE, OP_BREAD, OP_BMUL, OP_BSUB, OP_BDIV, OP_BLATCH, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic first_row;
        logic end_row;
        logic div_done;
        logic brow_zero;
    } status_t;

    // Saturate a 33-bit difference to the Q16.16 range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v > 33'sh0_7FFF_FFFF) begin
            res = Q_MAX;
        end
        else if (v < -33'sh0_8000_0000) begin
            res = Q_MIN;
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/tts_divider.sv @@
// -----------------------------------------------------------------------------
// Iterative signed divider
// Divides a 64-bit signed dividend by a 32-bit signed divisor, two quotient
// bits per cycle, truncating toward zero and saturating to Q16.16 range.
// -----------------------------------------------------------------------------
module tts_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot,
    output logic               den_zero
);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [63:0]       n_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       den_reg;
    logic              neg_reg;
    logic              num_neg_reg;
    logic              num_nz_reg;
    logic              zero_reg;
    logic signed [31:0] quot_reg;

    logic [32:0] r1;
    logic [32:0] r2;
    logic [31:0] rem1;
    logic [31:0] rem2;
    logic        b1;
    logic        b2;

    always_comb
    begin
        r1 = {rem_reg, n_reg[63]};
        b1 = (r1 >= {1'b0, den_reg});
        rem1 = b1 ? 32'(r1 - {1'b0, den_reg}) : r1[31:0];
        r2 = {rem1, n_reg[62]};
        b2 = (r2 >= {1'b0, den_reg});
        rem2 = b2 ? 32'(r2 - {1'b0, den_reg}) : r2[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            n_reg       <= num[63] ? 64'(-num) : 64'(num);
            den_reg     <= den[31] ? 32'(-den) : 32'(den);
            rem_reg     <= '0;
            neg_reg     <= num[63] ^ den[31];
            num_neg_reg <= num[63];
            num_nz_reg  <= (num != 64'sd0);
            zero_reg    <= (den == 32'sd0);
        end
        else if (busy_reg) begin
            n_reg   <= {n_reg[61:0], b1, b2};
            rem_reg <= rem2;
        end
        if (fin_reg) begin
            if (zero_reg) begin
                if (!num_nz_reg) begin
                    quot_reg <= '0;
                end
                else begin
                    quot_reg <= num_neg_reg ? tts_pkg::Q_MIN : tts_pkg::Q_MAX;
                end
            end
            else if (neg_reg) begin
                quot_reg <= (n_reg > 64'h8000_0000) ? tts_pkg::Q_MIN
                                                    : 32'(-n_reg[31:0]);
            end
            else begin
                quot_reg <= (n_reg > 64'h7FFF_FFFF) ? tts_pkg::Q_MAX : n_reg[31:0];
            end
        end
    end

    assign done     = done_reg;
    assign quot     = quot_reg;
    assign den_zero = zero_reg;

endmodule

@@ rtl/tts_datapath.sv @@
// -----------------------------------------------------------------------------
// Solver datapath
// Row stores, multiplier, dividers and the result register, driven by one
// operation code per cycle from the controller.
// -----------------------------------------------------------------------------
module tts_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tts_pkg::row_word_t    row_word,
    input  tts_pkg::ctrl_t        ctrl,
    output tts_pkg::status_t      status,
    output logic                  result_strobe,
    output tts_pkg::result_word_t result_word
);

    logic signed [31:0] pivot_mem   [tts_pkg::MAX_ROWS];
    logic signed [31:0] mod_rhs_mem [tts_pkg::MAX_ROWS];
    logic signed [31:0] super_mem   [tts_pkg::MAX_ROWS];

    tts_pkg::row_word_t in_reg;
    logic signed [31:0] prev_r_reg;
    logic signed [31:0] prev_y_reg;
    logic signed [31:0] prev_c_reg;
    logic signed [31:0] r_new_reg;
    logic signed [31:0] y_new_reg;
    logic signed [31:0] mem_r_reg;
    logic signed [31:0] mem_y_reg;
    logic signed [31:0] mem_c_reg;
    logic signed [31:0] x_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod2_reg;
    logic signed [63:0] bnum_reg;
    logic [tts_pkg::ROW_W-1:0] idx_reg;
    logic [tts_pkg::ROW_W-1:0] brow_reg;
    logic               sing_reg;
    logic               strobe_reg;
    tts_pkg::result_word_t res_reg;

    logic               start0;
    logic               start1;
    logic signed [63:0] num0;
    logic signed [31:0] den0;
    logic               done0;
    logic               done1;
    logic signed [31:0] q0;
    logic signed [31:0] q1;
    logic               z0;
    logic               z1;

    assign start0 = (ctrl.op == tts_pkg::OP_FDIV) || (ctrl.op == tts_pkg::OP_BDIV);
    assign start1 = (ctrl.op == tts_pkg::OP_FDIV);
    assign num0   = (ctrl.op == tts_pkg::OP_BDIV) ? bnum_reg : prod_reg;
    assign den0   = (ctrl.op == tts_pkg::OP_BDIV) ? mem_r_reg : prev_r_reg;

    tts_divider u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start0),
        .num      (num0),
        .den      (den0),
        .done     (done0),
        .quot     (q0),
        .den_zero (z0)
    );

    tts_divider u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start1),
        .num      (prod2_reg),
        .den      (prev_r_reg),
        .done     (done1),
        .quot     (q1),
        .den_zero (z1)
    );

    always_comb
    begin
        status.first_row = (idx_reg == '0);
        status.end_row   = in_reg.last_row ||
                           (idx_reg == tts_pkg::ROW_W'(tts_pkg::MAX_ROWS - 1));
        status.div_done  = done0;
        status.brow_zero = (brow_reg == '0);
    end

    // Control state of the run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg    <= '0;
            brow_reg   <= '0;
            sing_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else begin
            strobe_reg <= (ctrl.op == tts_pkg::OP_EMIT);
            case (ctrl.op)
                tts_pkg::OP_FLATCH: sing_reg <= sing_reg | z0 | (done1 & z1);
                tts_pkg::OP_BLATCH: sing_reg <= sing_reg | z0;
                tts_pkg::OP_WRITE:
                begin
                    if (status.end_row) begin
                        brow_reg <= idx_reg;
                    end
                    else begin
                        idx_reg <= idx_reg + tts_pkg::ROW_W'(1);
                    end
                end
                tts_pkg::OP_EMIT:
                begin
                    if (brow_reg == '0) begin
                        idx_reg  <= '0;
                        sing_reg <= 1'b0;
                    end
                    else begin
                        brow_reg <= brow_reg - tts_pkg::ROW_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers and stores.
    always_ff @(posedge clk)
    begin
        mem_r_reg <= pivot_mem[brow_reg];
        mem_y_reg <= mod_rhs_mem[brow_reg];
        mem_c_reg <= super_mem[brow_reg];
        case (ctrl.op)
            tts_pkg::OP_LOAD:  in_reg <= row_word;
            tts_pkg::OP_SEED:
            begin
                r_new_reg <= in_reg.diag_coef;
                y_new_reg <= in_reg.rhs_value;
            end
            tts_pkg::OP_MUL_C: prod_reg  <= 64'(in_reg.sub_coef) * 64'(prev_c_reg);
            tts_pkg::OP_MUL_Y: prod2_reg <= 64'(in_reg.sub_coef) * 64'(prev_y_reg);
            tts_pkg::OP_FLATCH:
            begin
                r_new_reg <= tts_pkg::sat33(33'(in_reg.diag_coef) - 33'(q0));
                y_new_reg <= tts_pkg::sat33(33'(in_reg.rhs_value) - 33'(q1));
            end
            tts_pkg::OP_WRITE:
            begin
                pivot_mem[idx_reg]   <= r_new_reg;
                mod_rhs_mem[idx_reg] <= y_new_reg;
                super_mem[idx_reg]   <= in_reg.super_coef;
                prev_r_reg <= r_new_reg;
                prev_y_reg <= y_new_reg;
                prev_c_reg <= in_reg.super_coef;
                x_reg      <= '0;
            end
            tts_pkg::OP_BMUL:  prod_reg <= 64'(mem_c_reg) * 64'(x_reg);
            tts_pkg::OP_BSUB:
                bnum_reg <= {{16{mem_y_reg[31]}}, mem_y_reg, 16'h0000} - prod_reg;
            tts_pkg::OP_BLATCH: x_reg <= q0;
            tts_pkg::OP_EMIT:
            begin
                res_reg.solution_value <= x_reg;
                res_reg.row_index      <= brow_reg;
                res_reg.last_out       <= (brow_reg == '0);
                res_reg.singular       <= sing_reg;
            end
            default: ;
        endcase
    end

    assign result_strobe = strobe_reg;
    assign result_word   = res_reg;

endmodule

@@ rtl/tts_controller.sv @@
// -----------------------------------------------------------------------------
// Solver controller
// Sequences forward elimination per row and back substitution per run.
// -----------------------------------------------------------------------------
module tts_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  tts_pkg::status_t status,
    output tts_pkg::ctrl_t   ctrl,
    output logic             busy
);

    tts_pkg::state_t state_reg;
    tts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= tts_pkg::ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = tts_pkg::OP_NONE;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (start) begin
                    ctrl.op    = tts_pkg::OP_LOAD;
                    state_next = status.first_row ? tts_pkg::ST_SEED : tts_pkg::ST_MUL_C;
                end
            end
            tts_pkg::ST_SEED:
            begin
                ctrl.op    = tts_pkg::OP_SEED;
                state_next = tts_pkg::ST_WRITE;
            end
            tts_pkg::ST_MUL_C:
            begin
                ctrl.op    = tts_pkg::OP_MUL_C;
                state_next = tts_pkg::ST_MUL_Y;
            end
            tts_pkg::ST_MUL_Y:
            begin
                ctrl.op    = tts_pkg::OP_MUL_Y;
                state_next = tts_pkg::ST_FDIV;
            end
            tts_pkg::ST_FDIV:
            begin
                ctrl.op    = tts_pkg::OP_FDIV;
                state_next = tts_pkg::ST_FWAIT;
            end
            tts_pkg::ST_FWAIT:
            begin
                if (status.div_done) begin
                    ctrl.op    = tts_pkg::OP_FLATCH;
                    state_next = tts_pkg::ST_WRITE;
                end
            end
            tts_pkg::ST_WRITE:
            begin
                ctrl.op    = tts_pkg::OP_WRITE;
                state_next = status.end_row ? tts_pkg::ST_BREAD : tts_pkg::ST_IDLE;
            end
            tts_pkg::ST_BREAD:
            begin
                ctrl.op    = tts_pkg::OP_BREAD;
                state_next = tts_pkg::ST_BMUL;
            end
            tts_pkg::ST_BMUL:
            begin
                ctrl.op    = tts_pkg::OP_BMUL;
                state_next = tts_pkg::ST_BSUB;
            end
            tts_pkg::ST_BSUB:
            begin
                ctrl.op    = tts_pkg::OP_BSUB;
                state_next = tts_pkg::ST_BDIV;
            end
            tts_pkg::ST_BDIV:
            begin
                ctrl.op    = tts_pkg::OP_BDIV;
                state_next = tts_pkg::ST_BWAIT;
            end
            tts_pkg::ST_BWAIT:
            begin
                if (status.div_done) begin
                    ctrl.op    = tts_pkg::OP_BLATCH;
                    state_next = tts_pkg::ST_EMIT;
                end
            end
            tts_pkg::ST_EMIT:
            begin
                ctrl.op    = tts_pkg::OP_EMIT;
                state_next = status.brow_zero ? tts_pkg::ST_IDLE : tts_pkg::ST_BREAD;
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != tts_pkg::ST_IDLE);

endmodule

@@ rtl/tridiagonal_thomas_solver_unit.sv @@
// -----------------------------------------------------------------------------
// Tridiagonal Thomas solver unit
// Solves one tridiagonal Q16.16 system row by row, then streams the solution.
// -----------------------------------------------------------------------------
// Rows of one system are written one word at a time: a row is taken when
// start is high and busy is low. Each row runs forward elimination as it
// arrives, which keeps busy high through the multiplies and the iterative
// divider that retires two quotient bits per cycle; the first row of a
// system skips the division. After the row marked last (or the
// sixty-fourth row) the unit stays busy for back substitution and
// presents one solution word per row, highest row first, on result_word
// for a single cycle with result_strobe high. There is no way to hold
// results off, so the receiver must take each word in the cycle it
// appears. The word for row zero carries last_out, and every
// word of a run carries the same singular flag, which is set when any
// pivot of that system was zero; such quotients saturate instead of
// faulting. The unit is ready for a new system as soon as busy drops.
// -----------------------------------------------------------------------------
module tridiagonal_thomas_solver_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tts_pkg::row_word_t    row_word,
    output logic                  result_strobe,
    output tts_pkg::result_word_t result_word
);

    // Operation code from the controller and flags back from the datapath.
    tts_pkg::ctrl_t   ctrl;
    tts_pkg::status_t status;

    tts_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    tts_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_word      (row_word),
        .ctrl          (ctrl),
        .status        (status),
        .result_strobe (result_strobe),
        .result_word   (result_word)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tridiagonal solver unit testbench
// Feeds whole systems row by row, predicts every solution word in Q16.16
// and compares each strobed word against the oldest predicted one.
// -----------------------------------------------------------------------------
module tb;

    localparam longint Q16_ONE = 64'sd65536;
    localparam longint SAT_HI  = 64'sd2147483647;
    localparam longint SAT_LO  = -64'sd2147483648;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    tts_pkg::row_word_t    row_word = '0;
    logic                  result_strobe;
    tts_pkg::result_word_t result_word;

    tridiagonal_thomas_solver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .row_word      (row_word),
        .result_strobe (result_strobe),
        .result_word   (result_word)
    );

    always #5 clk = ~clk;

    // Rows waiting to be sent; the head is the word currently offered.
    tts_pkg::row_word_t    pending_rows[$];
    // Solution words predicted but not yet seen on the result port.
    tts_pkg::result_word_t solution_queue[$];
    int                    error_count = 0;

    // The predictor's own copy of the elimination state.
    longint pivot_mem[tts_pkg::MAX_ROWS];
    longint rhs_mem[tts_pkg::MAX_ROWS];
    longint super_mem[tts_pkg::MAX_ROWS];
    int     rows_held = 0;
    bit     zero_pivot = 1'b0;

    function automatic longint clip_q(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // Quotient truncated toward zero, saturated; a zero divisor marks the
    // system singular and saturates by the sign of the dividend.
    function automatic longint quot_q(longint num, longint den);
        if (den == 0) begin
            zero_pivot = 1'b1;
            if (num > 0) return SAT_HI;
            if (num < 0) return SAT_LO;
            return 0;
        end
        return clip_q(num / den);
    endfunction

    // Runs one forward elimination step and, when the system closes,
    // back substitution, queueing the words the unit should produce.
    function automatic void eliminate_row(tts_pkg::row_word_t w);
        longint a, b, c, d, r, y, x;
        longint sol[tts_pkg::MAX_ROWS];
        int j, k, row;
        tts_pkg::result_word_t res;
        a = w.sub_coef;
        b = w.diag_coef;
        c = w.super_coef;
        d = w.rhs_value;
        j = (rows_held >= tts_pkg::MAX_ROWS) ? tts_pkg::MAX_ROWS - 1 : rows_held;
        if (j == 0) begin
            r = b;
            y = d;
        end
        else begin
            r = clip_q(b - quot_q(a * super_mem[j-1], pivot_mem[j-1]));
            y = clip_q(d - quot_q(a * rhs_mem[j-1], pivot_mem[j-1]));
        end
        pivot_mem[j] = r;
        rhs_mem[j]   = y;
        super_mem[j] = c;
        rows_held    = j + 1;
        if (!w.last_row && j != tts_pkg::MAX_ROWS - 1) return;
        x = quot_q(rhs_mem[j] * Q16_ONE, pivot_mem[j]);
        for (k = 0; k <= j; k++) begin
            row = j - k;
            if (k > 0)
                x = quot_q(rhs_mem[row] * Q16_ONE - super_mem[row] * x, pivot_mem[row]);
            sol[k] = x;
        end
        // The singular flag covers every pivot of the run, so it is
        // attached only after all quotients are known.
        for (k = 0; k <= j; k++) begin
            res.solution_value = sol[k][31:0];
            res.row_index      = tts_pkg::ROW_W'(j - k);
            res.last_out       = (k == j);
            res.singular       = zero_pivot;
            solution_queue.push_back(res);
        end
        rows_held  = 0;
        zero_pivot = 1'b0;
    endfunction

    function automatic tts_pkg::row_word_t make_row(int a, int b, int c, int d, bit last);
        tts_pkg::row_word_t w;
        w.sub_coef   = a;
        w.diag_coef  = b;
        w.super_coef = c;
        w.rhs_value  = d;
        w.last_row   = last;
        return w;
    endfunction

    // Mostly modest values, so systems stay well conditioned, with full
    // range words and zeros mixed in to reach saturation and singularity.
    function automatic int pick_coef(int span);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 0;
        if (sel < 5) return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Driver: offers the head of the pending queue and inserts idle bursts
    // after accepted words, except in the final stretch of the run.
    int idle_left = 0;
    always @(posedge clk) begin
        logic next_start;
        next_start = start;
        if (rst_n) begin
            if (start && !busy) begin
                eliminate_row(row_word);
                void'(pending_rows.pop_front());
                next_start = 1'b0;
                if (pending_rows.size() > 30 && $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 17);
            end
            if (idle_left > 0) begin
                idle_left--;
                next_start = 1'b0;
            end
            else if (!next_start && pending_rows.size() > 0) begin
                next_start = 1'b1;
                row_word  <= pending_rows[0];
            end
        end
        start <= next_start;
    end

    // Monitor: every strobed word must match the oldest prediction.
    always @(posedge clk) begin
        tts_pkg::result_word_t want;
        if (rst_n && result_strobe) begin
            if (solution_queue.size() == 0) begin
                error_count++;
                $display("%0t unexpected word: got value %h row %0d last %b sing %b",
                         $time, result_word.solution_value, result_word.row_index,
                         result_word.last_out, result_word.singular);
            end
            else begin
                want = solution_queue.pop_front();
                if (result_word !== want) begin
                    error_count++;
                    $display("%0t mismatch: expected value %h row %0d last %b sing %b",
                             $time, want.solution_value, want.row_index,
                             want.last_out, want.singular);
                    $display("%0t          actual   value %h row %0d last %b sing %b",
                             $time, result_word.solution_value, result_word.row_index,
                             result_word.last_out, result_word.singular);
                end
            end
        end
    end

    initial begin
        int n, i, s;
        // Single-row systems: plain quotient, zero pivot with each sign of
        // the right-hand side, and extreme operands, the last of them saturating.
        pending_rows.push_back(make_row(0, 32'h0001_0000, 0, 32'h0003_0000, 1));
        pending_rows.push_back(make_row(5, 0, 7, 32'h0002_0000, 1));
        pending_rows.push_back(make_row(5, 0, 7, -32'sh0002_0000, 1));
        pending_rows.push_back(make_row(5, 0, 7, 0, 1));
        pending_rows.push_back(make_row(-1, 32'h8000_0000, -1, 32'h7FFF_FFFF, 1));
        pending_rows.push_back(make_row(32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1));
        // Two rows with a zero first pivot, then two rows of extremes.
        pending_rows.push_back(make_row(0, 0, 32'h0001_0000, 32'h0001_0000, 0));
        pending_rows.push_back(make_row(32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000, 1));
        pending_rows.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h8000_0000, 0));
        pending_rows.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 1));
        // Three rows where elimination drives the middle pivot to zero.
        pending_rows.push_back(make_row(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0));
        pending_rows.push_back(make_row(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                        32'h0002_0000, 0));
        pending_rows.push_back(make_row(32'h0001_0000, 32'h0003_0000, 0, 32'h0001_0000, 1));
        // A system that never marks its end: the row stored at the top of
        // the stores closes it, and the next row opens a fresh system.
        for (i = 0; i < tts_pkg::MAX_ROWS; i++)
            pending_rows.push_back(make_row(32'hFFFF_0000, 32'h0004_0000, 32'hFFFF_0000,
                                            pick_coef(32'h0010_0000), 0));
        pending_rows.push_back(make_row(0, 32'h0002_0000, 0, 32'h0001_0000, 1));

        // Random systems, mostly short, now and then a long one.
        s = 0;
        while (s < 80) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                pending_rows.push_back(make_row(pick_coef(32'h0002_0000),
                                                pick_coef(32'h0008_0000),
                                                pick_coef(32'h0002_0000),
                                                pick_coef(32'h0020_0000),
                                                i == n - 1));
            s += n;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_rows.size() != 0 || start || solution_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
